>>> hw/rtl/narr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// narr_pkg
// Shared types and constants of the NACK ARQ reorder receiver.
// ----------------------------------------------------------------------------
package narr_pkg;

	localparam int unsigned SEQ_BITS     = 32;
	localparam int unsigned WORD_BITS    = 64;
	localparam int unsigned MS_BITS      = 10;
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned MAX_RESULTS  = 32;
	localparam int unsigned CNT_BITS     = 6;

	localparam logic [CFG_IDX_BITS-1:0] REG_DEADLINE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEADLINE_BASE   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRACE           = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RENACK          = 3'd4;

	localparam logic                KIND_NACK    = 1'b0;
	localparam logic                KIND_DELIVER = 1'b1;
	localparam logic                ACT_PACKET   = 1'b0;
	localparam logic                ACT_TICK     = 1'b1;

	typedef struct packed {
		logic                deadline_enable;
		logic [SEQ_BITS-1:0] deadline_base_ms;
		logic [MS_BITS-1:0]  frame_period_ms;
		logic [MS_BITS-1:0]  grace_ms;
		logic [MS_BITS-1:0]  repeat_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic                 kind;
		logic [SEQ_BITS-1:0]  seq;
		logic [WORD_BITS-1:0] payload;
		logic                 last;
	} result_t;

endpackage

>>> hw/rtl/narr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// narr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module narr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/narr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// narr_engine
// Sequencer over the slot and NACK memories: store, NACK pass, delivery.
// ----------------------------------------------------------------------------
module narr_engine #(
	parameter int unsigned RING_DEPTH   = 16,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  narr_pkg::cfg_t                          cfg,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    action,
	input  logic [narr_pkg::SEQ_BITS-1:0]           seq,
	input  logic [narr_pkg::WORD_BITS-1:0]          payload_word,
	input  logic [narr_pkg::SEQ_BITS-1:0]           now_ms,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output narr_pkg::result_t                       res
);

	localparam int unsigned IW  = $clog2(RING_DEPTH);
	localparam int unsigned SW  = $clog2(RING_DEPTH + 1);
	localparam int unsigned SB  = narr_pkg::SEQ_BITS;
	localparam int unsigned MW  = SB + PAYLOAD_BITS;
	localparam int unsigned NW  = 2 * SB;
	localparam int unsigned PW  = SB + narr_pkg::MS_BITS;
	localparam int unsigned DW  = PW + 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(RING_DEPTH - 1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MOD   = 10'b0000000010,
		ST_SA    = 10'b0000000100,
		ST_SB    = 10'b0000001000,
		ST_NINIT = 10'b0000010000,
		ST_NA    = 10'b0000100000,
		ST_NB    = 10'b0001000000,
		ST_DA    = 10'b0010000000,
		ST_DB    = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t                         state_q;
	logic                           started_q;
	logic [SB-1:0]                  next_q, highest_q, cur_q;
	logic [IW-1:0]                  next_idx_q, high_idx_q, cur_idx_q, rem_q;
	logic [SB-1:0]                  seq_q, now_q, sh_q;
	logic [PAYLOAD_BITS-1:0]        data_q;
	logic [2:0]                     mcnt_q;
	logic [SW-1:0]                  skips_q;
	logic [narr_pkg::CNT_BITS-1:0]  cnt_q;
	logic [RING_DEPTH-1:0]          slot_valid_q, nack_valid_q;
	logic                           pend_valid_q;
	narr_pkg::result_t              pend_q;
	logic [PW-1:0]                  prod_s1;
	logic [DW-1:0]                  base_grace_q;

	logic                           slot_we, slot_re, nack_we, nack_re;
	logic [IW-1:0]                  slot_waddr, slot_raddr;
	logic [MW-1:0]                  slot_wdata, slot_rdata;
	logic [NW-1:0]                  nack_wdata, nack_rdata;
	logic [IW-1:0]                  rem_n;
	logic [IW:0]                    mod_t;
	logic                           holds, nack_fresh, past_due, emit_req, cnt_full, go;
	narr_pkg::result_t              new_res;

	narr_ram #(.WIDTH(MW), .DEPTH(RING_DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	narr_ram #(.WIDTH(NW), .DEPTH(RING_DEPTH)) u_nack_ram (
		.clk   (clk),
		.we    (nack_we),
		.waddr (cur_idx_q),
		.wdata (nack_wdata),
		.re    (nack_re),
		.raddr (cur_idx_q),
		.rdata (nack_rdata)
	);

	// seq modulo ring depth, four bits per cycle
	always_comb begin
		rem_n = rem_q;
		mod_t = '0;
		for (int k = 0; k < 4; k++) begin
			mod_t = {rem_n, sh_q[SB-1-k]};
			if (mod_t >= (IW+1)'(RING_DEPTH)) begin
				mod_t = mod_t - (IW+1)'(RING_DEPTH);
			end
			rem_n = mod_t[IW-1:0];
		end
	end

	always_comb begin
		slot_re    = 1'b0;
		slot_raddr = rem_q;
		unique case (state_q)
			ST_SA:   begin slot_re = 1'b1; slot_raddr = rem_q;      end
			ST_NA:   begin slot_re = 1'b1; slot_raddr = cur_idx_q;  end
			ST_DA:   begin slot_re = 1'b1; slot_raddr = next_idx_q; end
			default: begin slot_re = 1'b0; slot_raddr = rem_q;      end
		endcase
		nack_re = (state_q == ST_NA);

		holds = (state_q == ST_DB) ?
			(slot_valid_q[next_idx_q] && slot_rdata[MW-1 -: SB] == next_q) :
			(slot_valid_q[cur_idx_q] && slot_rdata[MW-1 -: SB] == cur_q);
		nack_fresh = nack_valid_q[cur_idx_q] && nack_rdata[NW-1 -: SB] == cur_q &&
			((now_q - nack_rdata[SB-1:0]) < SB'(cfg.repeat_gap_ms));
		past_due = cfg.deadline_enable && (skips_q < SW'(RING_DEPTH)) &&
			({{(DW-SB){1'b0}}, now_q} > (DW'(prod_s1) + base_grace_q));

		emit_req = (state_q == ST_NB && !holds && !nack_fresh) ||
			(state_q == ST_DB && holds);
		cnt_full = (cnt_q == narr_pkg::CNT_BITS'(narr_pkg::MAX_RESULTS));
		go       = !emit_req || cnt_full || !pend_valid_q || res_ready;

		new_res.kind    = (state_q == ST_DB) ? narr_pkg::KIND_DELIVER : narr_pkg::KIND_NACK;
		new_res.seq     = (state_q == ST_DB) ? next_q : cur_q;
		new_res.payload = (state_q == ST_DB) ?
			narr_pkg::WORD_BITS'(slot_rdata[PAYLOAD_BITS-1:0]) : '0;
		new_res.last    = 1'b0;

		slot_we    = (state_q == ST_SB) && !(slot_valid_q[rem_q] &&
			slot_rdata[MW-1 -: SB] == seq_q);
		slot_waddr = rem_q;
		slot_wdata = {seq_q, data_q};
		nack_we    = (state_q == ST_NB) && emit_req && go;
		nack_wdata = {cur_q, now_q};

		res_valid = pend_valid_q && ((emit_req && !cnt_full) || state_q == ST_FIN);
		res       = pend_q;
		res.last  = (state_q == ST_FIN);
		in_ready  = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk) begin
		base_grace_q <= DW'(cfg.deadline_base_ms) + DW'(cfg.grace_ms);
		if (state_q == ST_DA) begin
			prod_s1 <= PW'(next_q) * PW'(cfg.frame_period_ms);
		end
		if (state_q == ST_IDLE && in_valid) begin
			seq_q  <= seq;
			now_q  <= now_ms;
			data_q <= payload_word[PAYLOAD_BITS-1:0];
		end
		if (emit_req && go && !cnt_full) begin
			pend_q <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			started_q    <= 1'b0;
			next_q       <= '0;
			highest_q    <= '0;
			next_idx_q   <= '0;
			high_idx_q   <= '0;
			cur_q        <= '0;
			cur_idx_q    <= '0;
			rem_q        <= '0;
			sh_q         <= '0;
			mcnt_q       <= '0;
			skips_q      <= '0;
			cnt_q        <= '0;
			slot_valid_q <= '0;
			nack_valid_q <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (emit_req && go && !cnt_full) begin
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						skips_q <= '0;
						sh_q    <= seq;
						rem_q   <= '0;
						mcnt_q  <= '0;
						if (action == narr_pkg::ACT_PACKET) begin
							state_q <= ST_MOD;
						end else if (started_q) begin
							state_q <= ST_NINIT;
						end
					end
				end
				ST_MOD: begin
					rem_q  <= rem_n;
					sh_q   <= sh_q << 4;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'd7) begin
						state_q <= ST_SA;
						if (!started_q) begin
							started_q  <= 1'b1;
							next_q     <= seq_q;
							next_idx_q <= rem_n;
							highest_q  <= seq_q;
							high_idx_q <= rem_n;
						end else if (seq_q > highest_q) begin
							highest_q  <= seq_q;
							high_idx_q <= rem_n;
						end
					end
				end
				ST_SA: begin
					state_q <= ST_SB;
				end
				ST_SB: begin
					if (slot_we) begin
						slot_valid_q[rem_q] <= 1'b1;
					end
					state_q <= ST_NINIT;
				end
				ST_NINIT: begin
					if ({1'b0, next_q} + (SB+1)'(RING_DEPTH) < {1'b0, highest_q}) begin
						cur_q     <= highest_q - SB'(RING_DEPTH);
						cur_idx_q <= high_idx_q;
					end else begin
						cur_q     <= next_q;
						cur_idx_q <= next_idx_q;
					end
					state_q <= ST_NA;
				end
				ST_NA: begin
					state_q <= (cur_q < highest_q) ? ST_NB : ST_DA;
				end
				ST_NB: begin
					if (go) begin
						if (nack_we) begin
							nack_valid_q[cur_idx_q] <= 1'b1;
						end
						cur_q     <= cur_q + 1'b1;
						cur_idx_q <= (cur_idx_q == IDX_LAST) ? '0 : cur_idx_q + 1'b1;
						state_q   <= ST_NA;
					end
				end
				ST_DA: begin
					state_q <= ST_DB;
				end
				ST_DB: begin
					if (holds || past_due) begin
						if (go) begin
							if (holds) begin
								slot_valid_q[next_idx_q] <= 1'b0;
							end else begin
								skips_q <= skips_q + 1'b1;
							end
							next_q <= next_q + 1'b1;
							if (next_q == '1 || next_idx_q == IDX_LAST) begin
								next_idx_q <= '0;
							end else begin
								next_idx_q <= next_idx_q + 1'b1;
							end
							state_q <= ST_DA;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!pend_valid_q || res_ready) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("result left pending in idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= narr_pkg::CNT_BITS'(narr_pkg::MAX_RESULTS))
		else $error("result count overrun");
	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skips_q <= SW'(RING_DEPTH))
		else $error("skip count overrun");
	a_nack_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB) |-> (cur_q < highest_q))
		else $error("NACK step outside window");
`endif

endmodule

>>> hw/rtl/nack_arq_reorder_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nack_arq_reorder_receiver_top
// Receiver of a NACK based ARQ link with reorder ring and in-order delivery.
// ----------------------------------------------------------------------------
// Packet: store, NACK pass over N window steps, delivery over M steps; tick: the last two,
// N the NACK window size (<= depth), M the deliveries plus skips (<= 2*depth).
// seq modulo depth runs in ST_MOD; every window or delivery step is a read, then a decide.
// A result waits in the engine until the next one or the item end, then passes one
// output register; a stalled output stalls the engine. Ticks before the first packet
// are dropped. Reset clears ring/NACK valid bits and sequence state; memories keep data.
module nack_arq_reorder_receiver_top #(
	parameter int unsigned RING_DEPTH   = 16,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [narr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [narr_pkg::SEQ_BITS-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [narr_pkg::SEQ_BITS-1:0]         seq,
	input  logic [narr_pkg::WORD_BITS-1:0]        payload_word,
	input  logic [narr_pkg::SEQ_BITS-1:0]         now_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  kind,
	output logic [narr_pkg::SEQ_BITS-1:0]         out_seq,
	output logic [narr_pkg::WORD_BITS-1:0]        out_payload,
	output logic                                  last
);

	narr_pkg::cfg_t    cfg_q;
	narr_pkg::result_t res, out_q;
	logic              res_valid, res_ready, out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadline_enable  <= 1'b0;
			cfg_q.deadline_base_ms <= 32'd40;
			cfg_q.frame_period_ms  <= 10'd20;
			cfg_q.grace_ms         <= 10'd1;
			cfg_q.repeat_gap_ms    <= 10'd25;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				narr_pkg::REG_DEADLINE_ENABLE: cfg_q.deadline_enable  <= cfg_data[0];
				narr_pkg::REG_DEADLINE_BASE:   cfg_q.deadline_base_ms <= cfg_data;
				narr_pkg::REG_FRAME_PERIOD:
					cfg_q.frame_period_ms <= cfg_data[narr_pkg::MS_BITS-1:0];
				narr_pkg::REG_GRACE:    cfg_q.grace_ms  <= cfg_data[narr_pkg::MS_BITS-1:0];
				narr_pkg::REG_RENACK:
					cfg_q.repeat_gap_ms <= cfg_data[narr_pkg::MS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	narr_engine #(
		.RING_DEPTH   (RING_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.seq          (seq),
		.payload_word (payload_word),
		.now_ms       (now_ms),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// hold the result until taken
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign out_seq     = out_q.seq;
	assign out_payload = out_q.payload;
	assign last        = out_q.last;

endmodule
